/* rtl/gmd_pkg.sv */
// Types, codes and constants of the gzip member deframer.
// Used by gzip_member_deframer_core; depends on nothing else.
package gmd_pkg;

  // Header walk phases, one-hot.
  typedef enum logic [12:0] {
    PH_MAGIC1  = 13'b0000000000001,
    PH_MAGIC2  = 13'b0000000000010,
    PH_METHOD  = 13'b0000000000100,
    PH_FLAGS   = 13'b0000000001000,
    PH_FIXED   = 13'b0000000010000,
    PH_XLEN_LO = 13'b0000000100000,
    PH_XLEN_HI = 13'b0000001000000,
    PH_EXTRA   = 13'b0000010000000,
    PH_NAME    = 13'b0000100000000,
    PH_COMMENT = 13'b0001000000000,
    PH_HCRC1   = 13'b0010000000000,
    PH_HCRC2   = 13'b0100000000000,
    PH_BODY    = 13'b1000000000000
  } phase_t;

  // Byte kind codes.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_TRAILER = 2'd2;
  localparam kind_t KIND_DROP    = 2'd3;

  // Error codes.
  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE       = 3'd0;
  localparam err_t ERR_NOT_GZIP   = 3'd1;
  localparam err_t ERR_BAD_METHOD = 3'd2;
  localparam err_t ERR_TRUNCATED  = 3'd3;
  localparam err_t ERR_NO_TRAILER = 3'd4;

  // Header section indexes for the section walk.
  typedef logic [2:0] section_t;
  localparam section_t SEC_FIXED   = 3'd0;
  localparam section_t SEC_EXTRA   = 3'd1;
  localparam section_t SEC_NAME    = 3'd2;
  localparam section_t SEC_COMMENT = 3'd3;
  localparam section_t SEC_HCRC    = 3'd4;

  // Format constants.
  localparam logic [7:0]  MAGIC_ID1      = 8'h1f;
  localparam logic [7:0]  MAGIC_ID2      = 8'h8b;
  localparam logic [7:0]  CM_DEFLATE     = 8'h08;
  localparam logic [31:0] MIN_MEMBER_LEN = 32'd18;
  localparam logic [32:0] TRAILER_LEN    = 33'd8;
  localparam logic [31:0] FIXED_LAST_POS = 32'd9;

  // FLG bit positions.
  localparam int FLG_FHCRC    = 1;
  localparam int FLG_FEXTRA   = 2;
  localparam int FLG_FNAME    = 3;
  localparam int FLG_FCOMMENT = 4;

  // Phase that follows a finished header section, as the flags select.
  function automatic phase_t section_after(input section_t done, input logic [7:0] flags);
    phase_t nxt;
    if (done < SEC_EXTRA && flags[FLG_FEXTRA]) begin
      nxt = PH_XLEN_LO;
    end else if (done < SEC_NAME && flags[FLG_FNAME]) begin
      nxt = PH_NAME;
    end else if (done < SEC_COMMENT && flags[FLG_FCOMMENT]) begin
      nxt = PH_COMMENT;
    end else if (done < SEC_HCRC && flags[FLG_FHCRC]) begin
      nxt = PH_HCRC1;
    end else begin
      nxt = PH_BODY;
    end
    return nxt;
  endfunction

endpackage

/* rtl/gzip_member_deframer_core.sv */
// gzip member deframer: walks the member header and tags every byte.
// Depends on gmd_pkg for phase type, codes and the section walk.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  config  | cfg_write, cfg_data[31:0] (member_length)       | in
//  input   | in_valid, in_stall, data_byte, start_flag       | in
//  output  | out_valid, out_stall, byte_out, byte_kind,      | out
//          | error_code, last_byte                           |
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// from the input register through one pass of phase logic into the result register.
// The parse state updates as an item moves from the input register into the
// result register, so each item sees the state its predecessor left.
// Reset is synchronous and clears the pipeline valids, the parse state and
// member_length. A stalled output holds its item; the input register keeps
// taking items while the result register drains in the same cycle.
module gzip_member_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [1:0]  byte_kind,
  output logic [2:0]  error_code,
  output logic        last_byte
);

  // Configuration and parse state.
  logic [31:0]     member_length;
  logic [31:0]     byte_position;
  gmd_pkg::phase_t parse_phase;
  logic [7:0]      flag_bits;
  logic [15:0]     extra_remaining;
  logic [7:0]      extra_length_low;
  gmd_pkg::err_t   sticky_error;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_adv;

  // Next values.
  logic [31:0]     byte_position_next;
  gmd_pkg::phase_t parse_phase_next;
  logic [7:0]      flag_bits_next;
  logic [15:0]     extra_remaining_next;
  logic [7:0]      extra_length_low_next;
  gmd_pkg::err_t   sticky_error_next;
  gmd_pkg::kind_t  kind_next;
  gmd_pkg::err_t   code_next;
  logic            last_next;

  // State as seen by this item, after an optional restart.
  logic [31:0]     eff_pos;
  gmd_pkg::phase_t eff_phase;
  logic [7:0]      eff_flags;
  logic [15:0]     eff_xrem;
  logic [7:0]      eff_xlo;
  gmd_pkg::err_t   eff_err;

  // Position arithmetic, one bit wider to avoid wrap.
  logic [32:0] p_ext;
  logic [32:0] size_ext;
  logic [32:0] p_plus1;
  logic [32:0] p_plus8;
  logic [32:0] p_plus9;
  logic [15:0] xlen;
  logic [33:0] xend;
  logic [15:0] xrem_dec;
  gmd_pkg::err_t new_err;

  // Handshake: the input register advances when the result register is free.
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      member_length <= 32'd0;
    end else if (cfg_write) begin
      member_length <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= data_byte;
      s1_start <= start_flag;
    end
  end

  // Restart view of the parse state.
  always_comb begin
    if (s1_start) begin
      eff_pos   = 32'd0;
      eff_phase = gmd_pkg::PH_MAGIC1;
      eff_flags = 8'd0;
      eff_xrem  = 16'd0;
      eff_xlo   = 8'd0;
      eff_err   = gmd_pkg::ERR_NONE;
    end else begin
      eff_pos   = byte_position;
      eff_phase = parse_phase;
      eff_flags = flag_bits;
      eff_xrem  = extra_remaining;
      eff_xlo   = extra_length_low;
      eff_err   = sticky_error;
    end
  end

  assign p_ext    = {1'b0, eff_pos};
  assign size_ext = {1'b0, member_length};
  assign p_plus1  = p_ext + 33'd1;
  assign p_plus8  = p_ext + gmd_pkg::TRAILER_LEN;
  assign p_plus9  = p_ext + gmd_pkg::TRAILER_LEN + 33'd1;
  assign xlen     = {s1_byte, eff_xlo};
  assign xend     = {1'b0, p_plus1} + {18'd0, xlen};
  assign xrem_dec = eff_xrem - 16'd1;

  // Per-byte phase logic.
  always_comb begin
    byte_position_next    = (eff_pos == 32'hFFFF_FFFF) ? eff_pos : eff_pos + 32'd1;
    parse_phase_next      = eff_phase;
    flag_bits_next        = eff_flags;
    extra_remaining_next  = eff_xrem;
    extra_length_low_next = eff_xlo;
    kind_next             = gmd_pkg::KIND_DROP;
    new_err               = gmd_pkg::ERR_NONE;
    last_next             = (p_plus1 == size_ext);

    if (eff_err != gmd_pkg::ERR_NONE) begin
      kind_next = gmd_pkg::KIND_DROP;
    end else if (eff_phase == gmd_pkg::PH_MAGIC1 &&
                 (member_length < gmd_pkg::MIN_MEMBER_LEN || s1_byte != gmd_pkg::MAGIC_ID1)) begin
      new_err = gmd_pkg::ERR_NOT_GZIP;
    end else if (p_ext >= size_ext) begin
      kind_next = gmd_pkg::KIND_DROP;
    end else if (eff_phase == gmd_pkg::PH_BODY) begin
      kind_next = (p_plus8 < size_ext) ? gmd_pkg::KIND_PAYLOAD : gmd_pkg::KIND_TRAILER;
    end else begin
      case (eff_phase)
        gmd_pkg::PH_MAGIC1: begin
          parse_phase_next = gmd_pkg::PH_MAGIC2;
        end
        gmd_pkg::PH_MAGIC2: begin
          if (s1_byte != gmd_pkg::MAGIC_ID2) new_err = gmd_pkg::ERR_NOT_GZIP;
          parse_phase_next = gmd_pkg::PH_METHOD;
        end
        gmd_pkg::PH_METHOD: begin
          if (s1_byte != gmd_pkg::CM_DEFLATE) new_err = gmd_pkg::ERR_BAD_METHOD;
          parse_phase_next = gmd_pkg::PH_FLAGS;
        end
        gmd_pkg::PH_FLAGS: begin
          flag_bits_next   = s1_byte;
          parse_phase_next = gmd_pkg::PH_FIXED;
        end
        gmd_pkg::PH_FIXED: begin
          if (eff_pos >= gmd_pkg::FIXED_LAST_POS) begin
            parse_phase_next = gmd_pkg::section_after(gmd_pkg::SEC_FIXED, eff_flags);
          end
        end
        gmd_pkg::PH_XLEN_LO: begin
          extra_length_low_next = s1_byte;
          parse_phase_next      = gmd_pkg::PH_XLEN_HI;
        end
        gmd_pkg::PH_XLEN_HI: begin
          // The extra field must end inside the member.
          if (xend > {1'b0, size_ext}) new_err = gmd_pkg::ERR_TRUNCATED;
          extra_remaining_next = xlen;
          parse_phase_next = (xlen == 16'd0) ?
                             gmd_pkg::section_after(gmd_pkg::SEC_EXTRA, eff_flags) :
                             gmd_pkg::PH_EXTRA;
        end
        gmd_pkg::PH_EXTRA: begin
          extra_remaining_next = xrem_dec;
          if (xrem_dec == 16'd0) begin
            parse_phase_next = gmd_pkg::section_after(gmd_pkg::SEC_EXTRA, eff_flags);
          end
        end
        gmd_pkg::PH_NAME: begin
          if (s1_byte == 8'd0) begin
            parse_phase_next = gmd_pkg::section_after(gmd_pkg::SEC_NAME, eff_flags);
          end
        end
        gmd_pkg::PH_COMMENT: begin
          if (s1_byte == 8'd0) begin
            parse_phase_next = gmd_pkg::section_after(gmd_pkg::SEC_COMMENT, eff_flags);
          end
        end
        gmd_pkg::PH_HCRC1: begin
          parse_phase_next = gmd_pkg::PH_HCRC2;
        end
        default: begin
          parse_phase_next = gmd_pkg::section_after(gmd_pkg::SEC_HCRC, eff_flags);
        end
      endcase

      // Header end needs trailer room; a header byte at the end truncates.
      if (new_err == gmd_pkg::ERR_NONE) begin
        if (parse_phase_next == gmd_pkg::PH_BODY) begin
          if (p_plus9 > size_ext) new_err = gmd_pkg::ERR_NO_TRAILER;
        end else if (p_plus1 >= size_ext) begin
          new_err = gmd_pkg::ERR_TRUNCATED;
        end
      end
      kind_next = (new_err != gmd_pkg::ERR_NONE) ? gmd_pkg::KIND_DROP : gmd_pkg::KIND_HEADER;
    end

    sticky_error_next = (new_err != gmd_pkg::ERR_NONE) ? new_err : eff_err;
    code_next         = (eff_err != gmd_pkg::ERR_NONE) ? eff_err : new_err;
  end

  // Parse state registers, updated as each item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 32'd0;
      parse_phase      <= gmd_pkg::PH_MAGIC1;
      flag_bits        <= 8'd0;
      extra_remaining  <= 16'd0;
      extra_length_low <= 8'd0;
      sticky_error     <= gmd_pkg::ERR_NONE;
    end else if (s1_adv) begin
      byte_position    <= byte_position_next;
      parse_phase      <= parse_phase_next;
      flag_bits        <= flag_bits_next;
      extra_remaining  <= extra_remaining_next;
      extra_length_low <= extra_length_low_next;
      sticky_error     <= sticky_error_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      byte_out   <= s1_byte;
      byte_kind  <= kind_next;
      error_code <= code_next;
      last_byte  <= last_next;
    end
  end

  // Any reported error marks the byte as dropped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != gmd_pkg::ERR_NONE |-> byte_kind == gmd_pkg::KIND_DROP)
    else $error("error reported on a byte that is not dropped");

  // A held error is repeated on the next byte unless it restarts the parse.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_start && sticky_error != gmd_pkg::ERR_NONE
    |=> error_code == $past(sticky_error) && byte_kind == gmd_pkg::KIND_DROP)
    else $error("sticky error not carried to the next byte");

  // Once in the body, only a restart leaves it.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && !s1_start && parse_phase == gmd_pkg::PH_BODY |=> parse_phase == gmd_pkg::PH_BODY)
    else $error("parse left the body phase without a restart");

endmodule

/* verif/gzip_member_deframer_core_tb.sv */
// Self-checking testbench for gzip_member_deframer_core: byte tagging, errors, member length.
// Depends on gmd_pkg and the core RTL; randomized members, stalls and idle gaps on both sides.
module gzip_member_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 5;
  localparam int ITEMS_WANTED  = 650;
  localparam int MAX_WAIT      = 18;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 500000;

  // Member shapes that the random part draws from.
  typedef enum int {
    SH_CLEAN, SH_BAD_MAGIC, SH_BAD_METHOD, SH_LONG_EXTRA, SH_CUT_HEADER,
    SH_NO_TRAILER, SH_PAST_END, SH_RESTART, SH_HUGE, SH_NOISE, SH_SHORT
  } shape_t;
  localparam int SH_COUNT = 11;

  // One expected tagged byte.
  typedef struct {
    logic [7:0]     data;
    gmd_pkg::kind_t kind;
    gmd_pkg::err_t  err;
    logic           last;
  } tag_t;

  // Header walk of the member and the queue of tags it has produced.
  class member_tagger;
    logic [31:0]     member_len;
    logic [31:0]     pos;
    gmd_pkg::phase_t walk_phase;
    logic [7:0]      flg;
    logic [15:0]     xrem;
    logic [7:0]      xlo;
    gmd_pkg::err_t   sticky;
    tag_t            due_tags[$];
    int unsigned     mismatches;

    function new();
      member_len = '0;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      pos        = '0;
      walk_phase = gmd_pkg::PH_MAGIC1;
      flg        = '0;
      xrem       = '0;
      xlo        = '0;
      sticky     = gmd_pkg::ERR_NONE;
    endfunction

    function void set_length(logic [31:0] len);
      member_len = len;
    endfunction

    // First enabled section after the one just finished, else the body.
    function gmd_pkg::phase_t phase_after(gmd_pkg::section_t done);
      gmd_pkg::phase_t nxt;
      nxt = gmd_pkg::PH_BODY;
      for (int s = gmd_pkg::SEC_HCRC; s > done; s--) begin
        case (gmd_pkg::section_t'(s))
          gmd_pkg::SEC_EXTRA:   if (flg[gmd_pkg::FLG_FEXTRA]) nxt = gmd_pkg::PH_XLEN_LO;
          gmd_pkg::SEC_NAME:    if (flg[gmd_pkg::FLG_FNAME]) nxt = gmd_pkg::PH_NAME;
          gmd_pkg::SEC_COMMENT: if (flg[gmd_pkg::FLG_FCOMMENT]) nxt = gmd_pkg::PH_COMMENT;
          gmd_pkg::SEC_HCRC:    if (flg[gmd_pkg::FLG_FHCRC]) nxt = gmd_pkg::PH_HCRC1;
          default: ;
        endcase
      end
      return nxt;
    endfunction

    // Advance the walk by one accepted byte and queue the tag it earns.
    function void note_byte(logic [7:0] b, logic st);
      logic [63:0]     size;
      logic [63:0]     p;
      logic [63:0]     xlen;
      gmd_pkg::phase_t nxt;
      tag_t            t;
      size = {32'd0, member_len};
      if (st) restart();
      p = {32'd0, pos};
      if (pos != 32'hFFFF_FFFF) pos = pos + 32'd1;
      t.data = b;
      t.last = (p < size) && (p + 64'd1 == size);
      t.kind = gmd_pkg::KIND_DROP;
      t.err  = gmd_pkg::ERR_NONE;
      if (sticky != gmd_pkg::ERR_NONE) begin
        t.err = sticky;
      end else if (walk_phase == gmd_pkg::PH_MAGIC1 &&
                   (size < gmd_pkg::MIN_MEMBER_LEN || b != gmd_pkg::MAGIC_ID1)) begin
        t.err = gmd_pkg::ERR_NOT_GZIP;
      end else if (p >= size) begin
        // Past the end of the member: dropped quietly.
      end else if (walk_phase == gmd_pkg::PH_BODY) begin
        t.kind = (p + gmd_pkg::TRAILER_LEN < size) ? gmd_pkg::KIND_PAYLOAD :
                                                     gmd_pkg::KIND_TRAILER;
      end else begin
        t.kind = gmd_pkg::KIND_HEADER;
        nxt = walk_phase;
        case (walk_phase)
          gmd_pkg::PH_MAGIC1: nxt = gmd_pkg::PH_MAGIC2;
          gmd_pkg::PH_MAGIC2: begin
            if (b != gmd_pkg::MAGIC_ID2) t.err = gmd_pkg::ERR_NOT_GZIP;
            nxt = gmd_pkg::PH_METHOD;
          end
          gmd_pkg::PH_METHOD: begin
            if (b != gmd_pkg::CM_DEFLATE) t.err = gmd_pkg::ERR_BAD_METHOD;
            nxt = gmd_pkg::PH_FLAGS;
          end
          gmd_pkg::PH_FLAGS: begin
            flg = b;
            nxt = gmd_pkg::PH_FIXED;
          end
          gmd_pkg::PH_FIXED: begin
            if (p >= gmd_pkg::FIXED_LAST_POS) nxt = phase_after(gmd_pkg::SEC_FIXED);
          end
          gmd_pkg::PH_XLEN_LO: begin
            xlo = b;
            nxt = gmd_pkg::PH_XLEN_HI;
          end
          gmd_pkg::PH_XLEN_HI: begin
            xlen = {48'd0, b, xlo};
            if (p + 64'd1 + xlen > size) t.err = gmd_pkg::ERR_TRUNCATED;
            xrem = xlen[15:0];
            nxt = (xlen == 64'd0) ? phase_after(gmd_pkg::SEC_EXTRA) : gmd_pkg::PH_EXTRA;
          end
          gmd_pkg::PH_EXTRA: begin
            xrem = xrem - 16'd1;
            if (xrem == 16'd0) nxt = phase_after(gmd_pkg::SEC_EXTRA);
          end
          gmd_pkg::PH_NAME:    if (b == 8'd0) nxt = phase_after(gmd_pkg::SEC_NAME);
          gmd_pkg::PH_COMMENT: if (b == 8'd0) nxt = phase_after(gmd_pkg::SEC_COMMENT);
          gmd_pkg::PH_HCRC1:   nxt = gmd_pkg::PH_HCRC2;
          default:             nxt = phase_after(gmd_pkg::SEC_HCRC);
        endcase
        // The header must end with room for the trailer, and must not be cut off.
        if (t.err == gmd_pkg::ERR_NONE) begin
          if (nxt == gmd_pkg::PH_BODY) begin
            if (p + 64'd1 + gmd_pkg::TRAILER_LEN > size) t.err = gmd_pkg::ERR_NO_TRAILER;
          end else if (p + 64'd1 >= size) begin
            t.err = gmd_pkg::ERR_TRUNCATED;
          end
        end
        walk_phase = nxt;
        if (t.err != gmd_pkg::ERR_NONE) t.kind = gmd_pkg::KIND_DROP;
      end
      if (t.err != gmd_pkg::ERR_NONE) sticky = t.err;
      due_tags.push_back(t);
    endfunction

    // Compare one delivered item against the oldest queued tag.
    function void check_tag(logic [7:0] d, gmd_pkg::kind_t k, gmd_pkg::err_t e, logic l);
      tag_t want;
      if (due_tags.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: byte %h kind %0d error %0d last %0b",
                 $time, d, k, e, l);
        return;
      end
      want = due_tags.pop_front();
      if (d !== want.data || k !== want.kind || e !== want.err || l !== want.last) begin
        mismatches++;
        $display("%0t: mismatch byte/kind/error/last: expected %h/%0d/%0d/%0b, actual %h/%0d/%0d/%0b",
                 $time, want.data, want.kind, want.err, want.last, d, k, e, l);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        start_flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  byte_out;
  logic [1:0]  byte_kind;
  logic [2:0]  error_code;
  logic        last_byte;

  member_tagger board;
  logic [7:0]   member_q[$];
  int           hdr_len;
  int           xlen_at;
  int unsigned  sent = 0;
  int unsigned  send_calm = 0;
  int unsigned  stall_calm = 0;
  int unsigned  cycles = 0;
  bit           hold_req = 1'b0;

  gzip_member_deframer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .start_flag (start_flag),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_out   (byte_out),
    .byte_kind  (byte_kind),
    .error_code (error_code),
    .last_byte  (last_byte)
  );

  always #HALF_PERIOD clk = ~clk;

  // Run limit; a hang ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("gzip_member_deframer_core_tb: errors");
      $finish;
    end
  end

  // Wait length for one item; now and then a stretch with no waiting at all.
  function automatic int draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    start_flag <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, st);
    sent++;
  endtask

  // Stop sending and wait until every queued tag has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Member length is written only with the block empty.
  task automatic write_length(input logic [31:0] len);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.set_length(len);
  endtask

  // Send the first count bytes of the built member, the first one restarting the parse.
  task automatic send_member(input int count);
    for (int i = 0; i < count; i++) send_byte(member_q[i], i == 0);
  endtask

  // Build a well-formed member with random flags, optional sections, payload and trailer.
  task automatic build_member(input bit long_name, input bit need_extra);
    logic [7:0] fl;
    int n;
    member_q.delete();
    fl = 8'($urandom_range(0, 255));
    if (long_name) fl[gmd_pkg::FLG_FNAME] = 1'b1;
    if (need_extra) fl[gmd_pkg::FLG_FEXTRA] = 1'b1;
    member_q.push_back(gmd_pkg::MAGIC_ID1);
    member_q.push_back(gmd_pkg::MAGIC_ID2);
    member_q.push_back(gmd_pkg::CM_DEFLATE);
    member_q.push_back(fl);
    repeat (6) member_q.push_back(8'($urandom_range(0, 255)));
    if (fl[gmd_pkg::FLG_FEXTRA]) begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      xlen_at = member_q.size();
      member_q.push_back(n[7:0]);
      member_q.push_back(n[15:8]);
      repeat (n) member_q.push_back(8'($urandom_range(0, 255)));
    end
    if (fl[gmd_pkg::FLG_FNAME]) begin
      n = long_name ? $urandom_range(10, 20) : $urandom_range(0, 6);
      repeat (n) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (fl[gmd_pkg::FLG_FCOMMENT]) begin
      repeat ($urandom_range(0, 6)) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'd0);
    end
    if (fl[gmd_pkg::FLG_FHCRC]) repeat (2) member_q.push_back(8'($urandom_range(0, 255)));
    hdr_len = member_q.size();
    n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24);
    repeat (n + 8) member_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // One configuration setting and the members sent under it.
  task automatic run_shape(input shape_t shape, input bit hold);
    logic [31:0] len;
    int reps;
    build_member(shape inside {SH_CUT_HEADER, SH_NO_TRAILER}, shape == SH_LONG_EXTRA);
    len = member_q.size();
    case (shape)
      SH_BAD_MAGIC:  member_q[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      SH_BAD_METHOD: member_q[2] ^= 8'($urandom_range(1, 255));
      SH_LONG_EXTRA: member_q[xlen_at + 1] = 8'($urandom_range(1, 255));
      SH_CUT_HEADER: len = $urandom_range(gmd_pkg::MIN_MEMBER_LEN, hdr_len - 1);
      SH_NO_TRAILER: len = hdr_len + $urandom_range(0, 7);
      SH_HUGE: len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      SH_NOISE: len = $urandom_range(0, 60);
      SH_SHORT: len = $urandom_range(1, gmd_pkg::MIN_MEMBER_LEN - 1);
      default: ;
    endcase
    if (shape inside {SH_CUT_HEADER, SH_NO_TRAILER})
      while (member_q.size() > len) void'(member_q.pop_back());
    write_length(len);
    if (hold) hold_req = 1'b1;
    case (shape)
      SH_CLEAN: begin
        reps = $urandom_range(1, 3);
        for (int r = 0; r < reps; r++) begin
          // Same header and length, fresh payload and trailer each time.
          for (int i = hdr_len; i < member_q.size(); i++)
            member_q[i] = 8'($urandom_range(0, 255));
          send_member(member_q.size());
        end
      end
      SH_PAST_END: begin
        send_member(member_q.size());
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      SH_RESTART: begin
        send_member($urandom_range(1, member_q.size() - 1));
        send_member(member_q.size());
      end
      SH_NOISE: begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat ($urandom_range(5, 30))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
      SH_SHORT: send_member($urandom_range(1, 4));
      default: send_member(member_q.size());
    endcase
  endtask

  // Directed opening: minimal member, past-end byte, bad magic, short member, bad method.
  task automatic directed_start();
    write_length(gmd_pkg::MIN_MEMBER_LEN);
    send_byte(gmd_pkg::MAGIC_ID1, 1'b1);
    send_byte(gmd_pkg::MAGIC_ID2, 1'b0);
    send_byte(gmd_pkg::CM_DEFLATE, 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (6 + 8) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    write_length(32'hFFFF_FFFF);
    send_byte(8'h1e, 1'b1);
    write_length(32'd0);
    send_byte(gmd_pkg::MAGIC_ID1, 1'b1);
    send_byte(8'h55, 1'b0);
    write_length(gmd_pkg::MIN_MEMBER_LEN);
    send_byte(gmd_pkg::MAGIC_ID1, 1'b1);
    send_byte(gmd_pkg::MAGIC_ID2, 1'b0);
    send_byte(8'h07, 1'b0);
  endtask

  // Receiver: random stalls per item, one long hold-off on request.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        n = draw_wait(stall_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_tag(byte_out, byte_kind, error_code, last_byte);
    end
  end

  // Sender: reset, directed part, then random members until enough items went in.
  initial begin
    int unsigned round;
    shape_t shape;
    bit held;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_start();
    round = 0;
    held = 1'b0;
    while (sent < ITEMS_WANTED) begin
      if (round < SH_COUNT) shape = shape_t'(round);
      else if ($urandom_range(0, 1) == 0) shape = SH_CLEAN;
      else shape = shape_t'($urandom_range(0, SH_COUNT - 1));
      run_shape(shape, shape == SH_CLEAN && (!held || $urandom_range(0, 7) == 0));
      if (shape == SH_CLEAN) held = 1'b1;
      round++;
    end
    settle();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.due_tags.size() == 0) begin
      $display("gzip_member_deframer_core_tb: clean");
    end else begin
      $display("gzip_member_deframer_core_tb: errors");
    end
    $finish;
  end

endmodule
